/* src/fragment_reassembly_tracker_defines.svh */
// Assertion macros for the fragment reassembly tracker
`ifndef FRAGMENT_REASSEMBLY_TRACKER_DEFINES_SVH
`define FRAGMENT_REASSEMBLY_TRACKER_DEFINES_SVH
`ifndef SYNTHESIS
`define FRT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define FRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define FRT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define FRT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* src/frt_pkg.sv */
`default_nettype none
package frt_pkg;
  localparam int TableEntries = 16;
  localparam int MaxPieces    = 32;
  localparam int MaxPayload   = 2047;
  localparam int EntW  = $clog2(TableEntries);
  localparam int PcW   = $clog2(MaxPieces);
  localparam int ExpW  = $clog2(MaxPieces + 1);
  localparam int PlW   = TableEntries * MaxPieces;
  localparam int PaW   = $clog2(PlW);
  localparam int QDepth = 2;

  typedef enum logic [1:0] {
    REQ_FRAG  = 2'd0,
    REQ_TICK  = 2'd1,
    REQ_SWEEP = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_PENDING  = 3'd0,
    ST_COMPLETE = 3'd1,
    ST_FULL     = 3'd2,
    ST_RANGE    = 3'd3,
    ST_TICK     = 3'd4,
    ST_SWEEP    = 3'd5
  } status_t;

  // classified command from front to back
  typedef struct packed {
    req_t         kind;
    logic         bad_num;
    logic [31:0]  host;
    logic [7:0]   msg;
    logic [PcW-1:0] num;
    logic         first;
    logic [10:0]  len;
  } cmd_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] host;
    logic [7:0]  msg;
    logic [15:0] total;
    logic [5:0]  count;
    logic [4:0]  removed;
  } res_t;
endpackage
`default_nettype wire

/* src/frt_ram.sv */
`default_nettype none
module frt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output      logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* src/frt_front.sv */
`default_nettype none
module frt_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output      logic            in_stall,
  input  wire logic [1:0]      in_req_type,
  input  wire logic [31:0]     in_host_id,
  input  wire logic [7:0]      in_message_id,
  input  wire logic [15:0]     in_fragment_number,
  input  wire logic            in_first_flag,
  input  wire logic [10:0]     in_payload_length,
  output      frt_pkg::cmd_t   q_cmd,
  output      logic            q_valid,
  input  wire logic            q_pop
);
  import frt_pkg::*;

  localparam int QAW = $clog2(QDepth);

  cmd_t           q_r [QDepth];
  logic [QAW-1:0] rd_r, rd_nxt, wr_r, wr_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;
  cmd_t           c;
  logic           push;

  // classify: range check and payload clamp
  always_comb begin
    c.kind    = req_t'(in_req_type);
    c.bad_num = (in_fragment_number >= 16'(MaxPieces));
    c.host    = in_host_id;
    c.msg     = in_message_id;
    c.num     = in_fragment_number[PcW-1:0];
    c.first   = in_first_flag;
    c.len     = (in_payload_length > 11'(MaxPayload)) ? 11'(MaxPayload)
                                                      : in_payload_length;
  end

  assign in_stall = (cnt_r == (QAW+1)'(QDepth));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign q_cmd    = q_r[rd_r];

  always_comb begin
    rd_nxt  = q_pop ? rd_r + 1'b1 : rd_r;
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    cnt_nxt = cnt_r + (QAW+1)'(push) - (QAW+1)'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= '0; wr_r <= '0; cnt_r <= '0;
    end else begin
      rd_r <= rd_nxt; wr_r <= wr_nxt; cnt_r <= cnt_nxt;
    end
  end

  // queue payload
  always_ff @(posedge clk) begin
    if (push) q_r[wr_r] <= c;
  end
endmodule
`default_nettype wire

/* src/frt_back.sv */
`default_nettype none
`include "fragment_reassembly_tracker_defines.svh"
module frt_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire frt_pkg::cmd_t q_cmd,
  input  wire logic          q_valid,
  output      logic          q_pop,
  input  wire logic [31:0]   age_limit,
  output      frt_pkg::res_t res,
  output      logic          res_valid,
  input  wire logic          res_take
);
  import frt_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LOOK  = 6'b000010,
    S_SUM   = 6'b000100,
    S_SWEEP = 6'b001000,
    S_OUT   = 6'b010000,
    S_WAIT  = 6'b100000
  } state_t;

  state_t              st_r, st_nxt;
  logic [TableEntries-1:0] valid_r;
  logic [31:0]         host_r [TableEntries];
  logic [7:0]          msg_r  [TableEntries];
  logic [MaxPieces-1:0] seen_r [TableEntries];
  logic [ExpW-1:0]     exp_r  [TableEntries];
  logic [31:0]         stamp_r [TableEntries];
  logic [31:0]         now_r;
  cmd_t                cmd_r;
  logic [EntW-1:0]     slot_r;
  logic [ExpW:0]       k_r;
  logic [ExpW-1:0]     cnt_r;
  logic [16:0]         sum_r;
  logic [EntW:0]       sw_r;
  logic [4:0]          rem_r;
  res_t                res_r;
  logic                ovalid_r;

  // table lookup
  logic              hit, has_free;
  logic [EntW-1:0]   hit_i, free_i;
  always_comb begin
    hit = 1'b0; has_free = 1'b0; hit_i = '0; free_i = '0;
    for (int i = TableEntries - 1; i >= 0; i--) begin
      if (valid_r[i] && host_r[i] == cmd_r.host && msg_r[i] == cmd_r.msg) begin
        hit = 1'b1; hit_i = EntW'(i);
      end
      if (!valid_r[i]) begin
        has_free = 1'b1; free_i = EntW'(i);
      end
    end
  end

  // piece length memory
  logic            pl_we;
  logic [PaW-1:0]  pl_waddr, pl_raddr;
  logic [10:0]     pl_rdata;
  frt_ram #(.Width(11), .Depth(PlW)) u_pl (
    .clk(clk), .we(pl_we), .waddr(pl_waddr), .wdata(cmd_r.len),
    .raddr(pl_raddr), .rdata(pl_rdata)
  );

  logic [EntW-1:0]     slot_w;
  logic [MaxPieces-1:0] seen_new, need;
  logic [ExpW-1:0]     exp_new;
  logic                look_go;
  assign slot_w   = hit ? hit_i : free_i;
  assign look_go  = (st_r == S_LOOK) && cmd_r.kind == REQ_FRAG && !cmd_r.bad_num
                    && (hit || has_free);
  assign pl_we    = look_go;
  assign pl_waddr = {slot_w, cmd_r.num};
  assign pl_raddr = {slot_r, k_r[PcW-1:0]};
  always_comb begin
    seen_new = (hit ? seen_r[hit_i] : '0) | (MaxPieces'(1) << cmd_r.num);
    exp_new  = cmd_r.first ? ExpW'(cmd_r.num) + 1'b1 : (hit ? exp_r[hit_i] : '0);
    need     = (exp_new == ExpW'(MaxPieces)) ? '1
             : ((MaxPieces'(1) << exp_new) - 1'b1);
  end

  logic [31:0] age;
  assign age = now_r - stamp_r[sw_r[EntW-1:0]];
  assign q_pop = (st_r == S_IDLE) && q_valid;
  assign res = res_r;
  assign res_valid = ovalid_r;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE:  if (q_valid) st_nxt = S_LOOK;
      S_LOOK: begin
        if (cmd_r.kind == REQ_SWEEP) st_nxt = S_SWEEP;
        else if (look_go && exp_new != '0 && (seen_new & need) == need)
          st_nxt = S_SUM;
        else st_nxt = S_OUT;
      end
      S_SUM:   if (k_r == (ExpW+1)'(cnt_r)) st_nxt = S_OUT;
      S_SWEEP: if (sw_r == (EntW+1)'(TableEntries - 1)) st_nxt = S_OUT;
      S_OUT:   st_nxt = S_WAIT;
      S_WAIT:  if (!ovalid_r || res_take) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; valid_r <= '0; now_r <= '0; ovalid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (res_take) ovalid_r <= 1'b0;
      unique case (st_r)
        S_LOOK: begin
          if (cmd_r.kind == REQ_TICK) now_r <= now_r + 1'b1;
          if (look_go) valid_r[slot_w] <= 1'b1;
        end
        S_SUM: if (k_r == (ExpW+1)'(cnt_r)) valid_r[slot_r] <= 1'b0;
        S_SWEEP: if (valid_r[sw_r[EntW-1:0]] && age > age_limit)
          valid_r[sw_r[EntW-1:0]] <= 1'b0;
        S_OUT: ovalid_r <= 1'b1;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (q_pop) cmd_r <= q_cmd;
    unique case (st_r)
      S_LOOK: begin
        res_r <= '0;
        k_r <= '0; sum_r <= '0; sw_r <= '0; rem_r <= '0;
        slot_r <= slot_w; cnt_r <= exp_new;
        unique case (cmd_r.kind)
          REQ_FRAG: res_r.status <= cmd_r.bad_num ? ST_RANGE
                                 : ((hit || has_free) ? ST_PENDING : ST_FULL);
          REQ_TICK: res_r.status <= ST_TICK;
          REQ_SWEEP: res_r.status <= ST_SWEEP;
          REQ_NONE: res_r.status <= ST_PENDING;
          default: ;
        endcase
        if (look_go) begin
          host_r[slot_w] <= cmd_r.host; msg_r[slot_w] <= cmd_r.msg;
          seen_r[slot_w] <= seen_new; exp_r[slot_w] <= exp_new;
          stamp_r[slot_w] <= now_r;
        end
      end
      S_SUM: begin
        // read address runs one ahead of the registered data
        k_r <= k_r + 1'b1;
        if (k_r != '0 && sum_r < 17'd65535)
          sum_r <= sum_r + 17'(pl_rdata);
        if (k_r == (ExpW+1)'(cnt_r)) begin
          res_r.status <= ST_COMPLETE;
          res_r.host <= cmd_r.host; res_r.msg <= cmd_r.msg;
          res_r.count <= 6'(cnt_r);
        end
      end
      S_SWEEP: begin
        sw_r <= sw_r + 1'b1;
        if (valid_r[sw_r[EntW-1:0]] && age > age_limit && rem_r != 5'd31)
          rem_r <= rem_r + 1'b1;
      end
      S_OUT: begin
        if (res_r.status == ST_COMPLETE)
          res_r.total <= (sum_r > 17'd65535) ? 16'hFFFF : sum_r[15:0];
        if (res_r.status == ST_SWEEP) res_r.removed <= rem_r;
      end
      default: ;
    endcase
  end

  `FRT_ASSERT_IMP(a_pop_idle, clk, rst_n, q_pop, st_r == S_IDLE)
  `FRT_ASSERT_NEXT(a_out_valid, clk, rst_n, st_r == S_OUT, ovalid_r)
  `FRT_ASSERT_IMP(a_idle_no_out, clk, rst_n, st_r == S_LOOK, !ovalid_r)
endmodule
`default_nettype wire

/* src/fragment_reassembly_tracker.sv */
`default_nettype none
// Fragment reassembly tracker.
// Input channel in_*: valid/stall; one item is a fragment, a time tick, a
// sweep of stale entries or a no-op; each gives exactly one result on out_*.
// Config channel cfg_*: valid/ready write of age_limit (reset 1000).
// A front stage classifies items into a two-entry queue; the back stage
// looks up the 16-entry table and updates it.
// A completing fragment sums its piece lengths (one piece length memory
// read per cycle); a sweep checks all 16 table entries (one table entry
// per cycle).
// The result sits in an output register until the receiver drops out_stall;
// the back stage waits for that, the queue keeps taking items until full.
// Reset (rst_n, synchronous) empties the table and clears time to zero.
module fragment_reassembly_tracker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [31:0] in_host_id,
  input  wire logic [7:0]  in_message_id,
  input  wire logic [15:0] in_fragment_number,
  input  wire logic        in_first_flag,
  input  wire logic [10:0] in_payload_length,
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [31:0] cfg_age_limit,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [2:0]  out_status,
  output      logic [31:0] out_done_host,
  output      logic [7:0]  out_done_message,
  output      logic [15:0] out_total_length,
  output      logic [5:0]  out_fragment_count,
  output      logic [4:0]  out_removed_count
);
  import frt_pkg::*;

  cmd_t        q_cmd;
  logic        q_valid, q_pop;
  res_t        res;
  logic [31:0] age_limit_r;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) age_limit_r <= 32'd1000;
    else if (cfg_valid) age_limit_r <= cfg_age_limit;
  end

  frt_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_req_type, .in_host_id,
    .in_message_id, .in_fragment_number, .in_first_flag, .in_payload_length,
    .q_cmd, .q_valid, .q_pop
  );

  frt_back u_back (
    .clk, .rst_n, .q_cmd, .q_valid, .q_pop, .age_limit(age_limit_r),
    .res, .res_valid(out_valid), .res_take(out_valid && !out_stall)
  );

  assign out_status         = res.status;
  assign out_done_host      = res.host;
  assign out_done_message   = res.msg;
  assign out_total_length   = res.total;
  assign out_fragment_count = res.count;
  assign out_removed_count  = res.removed;
endmodule
`default_nettype wire
